>>> rtl/hllc_pkg.sv
package hllc_pkg;

  // Signed Q8.24 value and a value with its saturation mark
  typedef logic signed [31:0] qv_t;
  typedef struct packed {
    logic ov;
    qv_t  v;
  } qr_t;

  localparam qv_t QONE  = 32'sh0100_0000;
  localparam qv_t QHALF = 32'sh0080_0000;

  // Configuration port
  localparam int              GAMMA_W     = 26;
  localparam logic [25:0]     GAMMA_RESET = 26'd23488102;
  localparam int              ADDR_W      = 3;
  localparam logic [ADDR_W-3:0] REG_GAMMA = '0;

  // Divider: magnitude, rounding add, range check, one quotient bit per stage, sign
  localparam int DIV_STEPS = 33;
  localparam int DIV_LAT   = DIV_STEPS + 4;
  // Square root: operand stage, then one root bit per stage
  localparam int ROOT_BITS = 28;
  localparam int SQRT_LAT  = ROOT_BITS + 1;

  localparam logic [1:0] REGION_LEFT  = 2'd0;
  localparam logic [1:0] REGION_RIGHT = 2'd1;
  localparam logic [1:0] REGION_LSTAR = 2'd2;
  localparam logic [1:0] REGION_RSTAR = 2'd3;

  typedef struct packed {
    qv_t rho_left;
    qv_t mom_left;
    qv_t energy_left;
    qv_t rho_right;
    qv_t mom_right;
    qv_t energy_right;
  } item_t;

  typedef struct packed {
    qv_t        flux_mass;
    qv_t        flux_momentum;
    qv_t        flux_energy;
    logic [1:0] wave_region;
    logic       error_flag;
  } result_t;

  function automatic qr_t q_sat(input logic signed [64:0] x);
    qr_t r;
    if (x > 65'sd2147483647) begin
      r.ov = 1'b1;
      r.v  = 32'sh7fff_ffff;
    end else if (x < -65'sd2147483648) begin
      r.ov = 1'b1;
      r.v  = 32'sh8000_0000;
    end else begin
      r.ov = 1'b0;
      r.v  = x[31:0];
    end
    return r;
  endfunction

  function automatic qr_t q_add(input qv_t a, input qv_t b);
    return q_sat(65'(a) + 65'(b));
  endfunction

  function automatic qr_t q_sub(input qv_t a, input qv_t b);
    return q_sat(65'(a) - 65'(b));
  endfunction

  // Product rounded to nearest, ties toward plus infinity
  function automatic qr_t q_mul(input qv_t a, input qv_t b);
    logic signed [63:0] pr;
    logic signed [64:0] rw;
    pr = 64'(a) * 64'(b);
    rw = 65'(pr) + 65'sd8388608;
    return q_sat(rw >>> 24);
  endfunction

  // Fold a saturation mark into an error bit and hand back the value
  function automatic qv_t q_take(input qr_t r, inout logic f);
    f = f | r.ov;
    return r.v;
  endfunction

  function automatic qv_t q_min(input qv_t a, input qv_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic qv_t q_max(input qv_t a, input qv_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [31:0] q_mag(input qv_t a);
    logic signed [32:0] w;
    w = 33'(a);
    return (w < 0) ? 32'(-w) : 32'(w);
  endfunction

endpackage

>>> rtl/hllc_div.sv
module hllc_div import hllc_pkg::*; (
  input  logic clk,
  input  qv_t  num,
  input  qv_t  den,
  output qr_t  quo
);

  localparam int NW = 57;

  logic [31:0]          a_mag;
  logic [31:0]          d_a;
  logic                 neg_a;
  logic                 zero_a;
  logic [NW-1:0]        n_b;
  logic [31:0]          d_b;
  logic                 neg_b;
  logic                 zero_b;

  logic [NW-1:0]        rem  [0:DIV_STEPS];
  logic [31:0]          dv   [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] qb   [0:DIV_STEPS];
  logic                 ng   [0:DIV_STEPS];
  logic                 zr   [0:DIV_STEPS];
  logic                 ovf  [0:DIV_STEPS];
  logic [DIV_STEPS:0]   qneg;

  // magnitudes and sign
  always_ff @(posedge clk) begin
    a_mag  <= q_mag(num);
    d_a    <= q_mag(den);
    neg_a  <= num[31] ^ den[31];
    zero_a <= (den == '0);
  end

  // add half the divisor for round to nearest
  always_ff @(posedge clk) begin
    n_b    <= NW'({a_mag, 24'b0}) + NW'(d_a >> 1);
    d_b    <= d_a;
    neg_b  <= neg_a;
    zero_b <= zero_a;
  end

  // quotient too large for the bits developed below
  always_ff @(posedge clk) begin
    rem[0] <= n_b;
    dv[0]  <= d_b;
    qb[0]  <= '0;
    ng[0]  <= neg_b;
    zr[0]  <= zero_b;
    ovf[0] <= (65'(n_b) >= {d_b, 33'b0});
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [64:0] sh;
    assign sh = 65'(dv[i]) << (DIV_STEPS - 1 - i);
    always_ff @(posedge clk) begin
      if (65'(rem[i]) >= sh) begin
        rem[i+1] <= rem[i] - sh[NW-1:0];
        qb[i+1]  <= qb[i] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - i));
      end else begin
        rem[i+1] <= rem[i];
        qb[i+1]  <= qb[i];
      end
      dv[i+1]  <= dv[i];
      ng[i+1]  <= ng[i];
      zr[i+1]  <= zr[i];
      ovf[i+1] <= ovf[i];
    end
  end

  assign qneg = -{1'b0, qb[DIV_STEPS]};

  // apply sign, saturate; a zero divisor gives zero with the mark
  always_ff @(posedge clk) begin
    priority if (zr[DIV_STEPS]) begin
      quo <= '{ov: 1'b1, v: '0};
    end else if (!ng[DIV_STEPS] && (ovf[DIV_STEPS] || qb[DIV_STEPS] > 33'h0_7fff_ffff)) begin
      quo <= '{ov: 1'b1, v: 32'sh7fff_ffff};
    end else if (ng[DIV_STEPS] && (ovf[DIV_STEPS] || qb[DIV_STEPS] > 33'h0_8000_0000)) begin
      quo <= '{ov: 1'b1, v: 32'sh8000_0000};
    end else begin
      quo <= '{ov: 1'b0, v: ng[DIV_STEPS] ? qneg[31:0] : qb[DIV_STEPS][31:0]};
    end
  end

endmodule

>>> rtl/hllc_sqrt.sv
module hllc_sqrt import hllc_pkg::*; (
  input  logic clk,
  input  qv_t  arg,
  output qv_t  root
);

  localparam int VW = 56;

  logic [VW-1:0]        rem [0:ROOT_BITS];
  logic [ROOT_BITS-1:0] res [0:ROOT_BITS];

  // operand magnitude scaled to Q.48
  always_ff @(posedge clk) begin
    rem[0] <= {q_mag(arg), 24'b0};
    res[0] <= '0;
  end

  // (res + 2^b)^2 - res^2 = res*2^(b+1) + 2^(2b): the two terms never overlap
  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
    localparam int B = ROOT_BITS - 1 - i;
    logic [VW:0] trial;
    assign trial = ((VW+1)'(res[i]) << (B + 1)) | ((VW+1)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if ((VW+1)'(rem[i]) >= trial) begin
        rem[i+1] <= rem[i] - trial[VW-1:0];
        res[i+1] <= res[i] | (ROOT_BITS'(1) << B);
      end else begin
        rem[i+1] <= rem[i];
        res[i+1] <= res[i];
      end
    end
  end

  assign root = qv_t'({{(32-ROOT_BITS){1'b0}}, res[ROOT_BITS]});

endmodule

>>> rtl/hllc_interface_flux_core.sv
// HLLC interface flux, one 1D Euler cell interface per beat, signed Q8.24.
//
// Input channel: drive item with the left and right conservative states and
// pulse start; the beat is taken on every edge where start is high and busy
// is low. busy stays low, so a new interface can enter on every cycle.
// Result channel: done is high for exactly one cycle with the fluxes, the
// wave region and the error flag on result. The receiver cannot stall, so
// there is no back-pressure anywhere in the pipe.
// Depth: done and result come from the output register behind the last ctx
// stage. The chain of dependent units sets the depth of the pipe:
// velocity divide, sound-speed divide, square root, contact-speed divide and
// the final star-region divides, each one bit per stage (37 stages per
// divider, 29 per root), plus short multiply/add stages between them.
// Throughput: one interface per clock, sustained.
// Configuration: gamma_ratio at byte address 0 on the APB-style port; write
// it only while no beat is in flight. Reset clears the valid chain, drops
// any beats in flight and loads gamma_ratio with 1.4.
module hllc_interface_flux_core import hllc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              done,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Stage map. A unit fed from stage k lines up with stage k plus its own
  // stage count; its result is folded into the context at the stage after.
  localparam int A1   = DIV_LAT + 1;          // velocity
  localparam int A2   = A1 + 1;               // m*u
  localparam int A3   = A2 + 1;               // half of it
  localparam int A4   = A3 + 1;               // E - m*u/2
  localparam int A5   = A4 + 1;               // pressure
  localparam int A6   = A5 + 1;               // g*p, physical flux terms
  localparam int A7   = A6 + 1;               // u*(E+p)
  localparam int B1   = A6 + DIV_LAT + 1;     // g*p/rho
  localparam int C1   = B1 + SQRT_LAT + 1;    // sound speed
  localparam int C2   = C1 + 1;               // min / max
  localparam int C3   = C2 + 1;               // SL, SR
  localparam int C4   = C3 + 1;               // S - u
  localparam int C5   = C4 + 1;               // products of S - u
  localparam int C6   = C5 + 1;
  localparam int C7   = C6 + 1;               // contact-speed numerator ready
  localparam int D1   = C7 + DIV_LAT + 1;     // SP
  localparam int D2   = D1 + 1;
  localparam int D3   = D2 + 1;
  localparam int D4   = D3 + 1;
  localparam int D5   = D4 + 1;
  localparam int D6   = D5 + 1;               // PLR, region, side select
  localparam int D7   = D6 + 1;
  localparam int D8   = D7 + 1;
  localparam int D9   = D8 + 1;
  localparam int D10  = D9 + 1;               // star numerators
  localparam int LAST = D10 + DIV_LAT;        // star quotients line up here

  typedef struct packed {
    logic       flt;     // error seen on every path
    logic       sflt;    // error seen on the star path only
    qv_t [1:0]  rho;
    qv_t [1:0]  mom;
    qv_t [1:0]  en;
    qv_t [1:0]  u;
    qv_t [1:0]  mu;
    qv_t [1:0]  h;
    qv_t [1:0]  eh;
    qv_t [1:0]  p;
    qv_t [1:0]  gp;
    qv_t [1:0]  f1;
    qv_t [1:0]  ep;
    qv_t [1:0]  f2;
    qv_t [1:0]  gr;
    qv_t [1:0]  c;
    qv_t        umin;
    qv_t        umax;
    qv_t        cmax;
    qv_t        sl;
    qv_t        sr;
    qv_t [1:0]  dd;
    qv_t [1:0]  a;
    qv_t [1:0]  b;
    qv_t        dp;
    qv_t        t1a;
    qv_t        t2;
    qv_t        t1;
    qv_t        sp;
    qv_t [1:0]  x;
    qv_t [1:0]  y;
    qv_t        pp;
    qv_t        z;
    qv_t        z2;
    qv_t        plr;
    logic [1:0] region;
    qv_t        s;
    qv_t [2:0]  qs;
    qv_t [2:0]  fs;
    qv_t [2:0]  sq;
    qv_t [2:0]  df;
    qv_t [2:0]  k;
    qv_t [2:0]  pm;
    qv_t [2:0]  num;
    qv_t        sp_pl;
    qv_t        den;
  } ctx_t;

  logic [GAMMA_W-1:0] gamma;
  qv_t                g;
  qv_t                gm;

  logic [LAST:0]      vld;
  ctx_t               c0;
  ctx_t               ctx [0:LAST];
  ctx_t               nxt [1:LAST];

  qr_t                u_quo  [2];
  qr_t                gr_quo [2];
  qv_t                root   [2];
  qr_t                sp_quo;
  qr_t                f_quo  [3];

  result_t            result_next;
  logic               star_err;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_GAMMA) ? 32'(gamma) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_GAMMA) begin
      gamma <= pwdata[GAMMA_W-1:0];
    end
  end

  assign g  = qv_t'(32'(gamma));
  assign gm = g - QONE;

  // Input side never holds off
  assign busy = 1'b0;

  always_comb begin
    c0               = '0;
    c0.rho[0]        = item.rho_left;
    c0.mom[0]        = item.mom_left;
    c0.en[0]         = item.energy_left;
    c0.rho[1]        = item.rho_right;
    c0.mom[1]        = item.mom_right;
    c0.en[1]         = item.energy_right;
    c0.flt           = (item.rho_left <= 0) || (item.rho_right <= 0);
  end

  // Valid bits travel beside the context
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAST-1:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    ctx[0] <= c0;
    for (int t = 1; t <= LAST; t++) begin
      ctx[t] <= nxt[t];
    end
  end

  // Per-side units
  for (genvar s = 0; s < 2; s++) begin : g_side
    hllc_div u_div_vel (
      .clk (clk),
      .num (ctx[0].mom[s]),
      .den (ctx[0].rho[s]),
      .quo (u_quo[s])
    );
    hllc_div u_div_snd (
      .clk (clk),
      .num (ctx[A6].gp[s]),
      .den (ctx[A6].rho[s]),
      .quo (gr_quo[s])
    );
    hllc_sqrt u_sqrt (
      .clk  (clk),
      .arg  (ctx[B1].gr[s]),
      .root (root[s])
    );
  end

  hllc_div u_div_sp (
    .clk (clk),
    .num (ctx[C7].t1),
    .den (ctx[C7].t2),
    .quo (sp_quo)
  );

  for (genvar m = 0; m < 3; m++) begin : g_eq
    hllc_div u_div_flux (
      .clk (clk),
      .num (ctx[D10].num[m]),
      .den (ctx[D10].den),
      .quo (f_quo[m])
    );
  end

  // Stage logic: every stage copies the context; some stages add their own terms
  always_comb begin
    for (int t = 1; t <= LAST; t++) begin
      nxt[t] = ctx[t-1];
    end

    for (int s = 0; s < 2; s++) begin
      nxt[A1].u[s]  = q_take(u_quo[s], nxt[A1].flt);
      nxt[A2].mu[s] = q_take(q_mul(ctx[A2-1].mom[s], ctx[A2-1].u[s]), nxt[A2].flt);
      nxt[A3].h[s]  = q_take(q_mul(QHALF, ctx[A3-1].mu[s]), nxt[A3].flt);
      nxt[A4].eh[s] = q_take(q_sub(ctx[A4-1].en[s], ctx[A4-1].h[s]), nxt[A4].flt);
      nxt[A5].p[s]  = q_take(q_mul(gm, ctx[A5-1].eh[s]), nxt[A5].flt);
      nxt[A6].gp[s] = q_take(q_mul(g, ctx[A6-1].p[s]), nxt[A6].flt);
      nxt[A6].f1[s] = q_take(q_add(ctx[A6-1].mu[s], ctx[A6-1].p[s]), nxt[A6].flt);
      nxt[A6].ep[s] = q_take(q_add(ctx[A6-1].en[s], ctx[A6-1].p[s]), nxt[A6].flt);
      nxt[A7].f2[s] = q_take(q_mul(ctx[A7-1].u[s], ctx[A7-1].ep[s]), nxt[A7].flt);
      nxt[B1].gr[s] = q_take(gr_quo[s], nxt[B1].flt);
      nxt[C1].c[s]  = root[s];
    end

    // Davis wave speeds
    nxt[C2].umin = q_min(ctx[C2-1].u[0], ctx[C2-1].u[1]);
    nxt[C2].umax = q_max(ctx[C2-1].u[0], ctx[C2-1].u[1]);
    nxt[C2].cmax = q_max(ctx[C2-1].c[0], ctx[C2-1].c[1]);
    nxt[C3].sl   = q_take(q_sub(ctx[C3-1].umin, ctx[C3-1].cmax), nxt[C3].flt);
    nxt[C3].sr   = q_take(q_add(ctx[C3-1].umax, ctx[C3-1].cmax), nxt[C3].flt);
    nxt[C4].dd[0] = q_take(q_sub(ctx[C4-1].sl, ctx[C4-1].u[0]), nxt[C4].flt);
    nxt[C4].dd[1] = q_take(q_sub(ctx[C4-1].sr, ctx[C4-1].u[1]), nxt[C4].flt);
    for (int s = 0; s < 2; s++) begin
      nxt[C5].a[s] = q_take(q_mul(ctx[C5-1].mom[s], ctx[C5-1].dd[s]), nxt[C5].flt);
      nxt[C5].b[s] = q_take(q_mul(ctx[C5-1].rho[s], ctx[C5-1].dd[s]), nxt[C5].flt);
    end
    nxt[C5].dp  = q_take(q_sub(ctx[C5-1].p[1], ctx[C5-1].p[0]), nxt[C5].flt);
    nxt[C6].t1a = q_take(q_add(ctx[C6-1].dp, ctx[C6-1].a[0]), nxt[C6].flt);
    nxt[C6].t2  = q_take(q_sub(ctx[C6-1].b[0], ctx[C6-1].b[1]), nxt[C6].flt);
    nxt[C7].t1  = q_take(q_sub(ctx[C7-1].t1a, ctx[C7-1].a[1]), nxt[C7].flt);

    // Contact speed (zero denominator gives zero and flags) and star pressure
    nxt[D1].sp = q_take(sp_quo, nxt[D1].flt);
    for (int s = 0; s < 2; s++) begin
      nxt[D2].x[s] = q_take(q_sub(ctx[D2-1].sp, ctx[D2-1].u[s]), nxt[D2].flt);
      nxt[D3].y[s] = q_take(q_mul(ctx[D3-1].b[s], ctx[D3-1].x[s]), nxt[D3].flt);
    end
    nxt[D2].pp  = q_take(q_add(ctx[D2-1].p[0], ctx[D2-1].p[1]), nxt[D2].flt);
    nxt[D4].z   = q_take(q_add(ctx[D4-1].pp, ctx[D4-1].y[0]), nxt[D4].flt);
    nxt[D5].z2  = q_take(q_add(ctx[D5-1].z, ctx[D5-1].y[1]), nxt[D5].flt);
    nxt[D6].plr = q_take(q_mul(QHALF, ctx[D5].z2), nxt[D6].flt);

    // Region and star side
    priority if (!ctx[D5].sl[31]) begin
      nxt[D6].region = REGION_LEFT;
    end else if (ctx[D5].sr[31] || ctx[D5].sr == '0) begin
      nxt[D6].region = REGION_RIGHT;
    end else if (!ctx[D5].sp[31]) begin
      nxt[D6].region = REGION_LSTAR;
    end else begin
      nxt[D6].region = REGION_RSTAR;
    end
    if (!ctx[D5].sp[31]) begin
      nxt[D6].s     = ctx[D5].sl;
      nxt[D6].qs[0] = ctx[D5].rho[0];
      nxt[D6].qs[1] = ctx[D5].mom[0];
      nxt[D6].qs[2] = ctx[D5].en[0];
      nxt[D6].fs[0] = ctx[D5].mom[0];
      nxt[D6].fs[1] = ctx[D5].f1[0];
      nxt[D6].fs[2] = ctx[D5].f2[0];
    end else begin
      nxt[D6].s     = ctx[D5].sr;
      nxt[D6].qs[0] = ctx[D5].rho[1];
      nxt[D6].qs[1] = ctx[D5].mom[1];
      nxt[D6].qs[2] = ctx[D5].en[1];
      nxt[D6].fs[0] = ctx[D5].mom[1];
      nxt[D6].fs[1] = ctx[D5].f1[1];
      nxt[D6].fs[2] = ctx[D5].f2[1];
    end

    // Star flux numerators; their errors count only in a star region
    nxt[D7].sp_pl = q_take(q_mul(ctx[D6].s, ctx[D6].plr), nxt[D7].sflt);
    nxt[D7].den   = q_take(q_sub(ctx[D6].s, ctx[D6].sp), nxt[D7].sflt);
    for (int m = 0; m < 3; m++) begin
      nxt[D7].sq[m] = q_take(q_mul(ctx[D6].s, ctx[D6].qs[m]), nxt[D7].sflt);
      nxt[D8].df[m] = q_take(q_sub(ctx[D7].sq[m], ctx[D7].fs[m]), nxt[D8].sflt);
      nxt[D9].pm[m] = q_take(q_mul(ctx[D8].sp, ctx[D8].df[m]), nxt[D9].sflt);
      nxt[D10].num[m] = q_take(q_add(ctx[D9].pm[m], ctx[D9].k[m]), nxt[D10].sflt);
    end
    nxt[D8].k[0] = q_take(q_mul(ctx[D7].sp_pl, '0), nxt[D8].sflt);
    nxt[D8].k[1] = q_take(q_mul(ctx[D7].sp_pl, QONE), nxt[D8].sflt);
    nxt[D8].k[2] = q_take(q_mul(ctx[D7].sp_pl, ctx[D7].sp), nxt[D8].sflt);
  end

  // Output register: pick the region's flux and close the error flag
  assign star_err = ctx[LAST].sflt || f_quo[0].ov || f_quo[1].ov || f_quo[2].ov;

  always_comb begin
    result_next             = '0;
    result_next.wave_region = ctx[LAST].region;
    unique case (ctx[LAST].region)
      REGION_LEFT: begin
        result_next.flux_mass     = ctx[LAST].mom[0];
        result_next.flux_momentum = ctx[LAST].f1[0];
        result_next.flux_energy   = ctx[LAST].f2[0];
        result_next.error_flag    = ctx[LAST].flt;
      end
      REGION_RIGHT: begin
        result_next.flux_mass     = ctx[LAST].mom[1];
        result_next.flux_momentum = ctx[LAST].f1[1];
        result_next.flux_energy   = ctx[LAST].f2[1];
        result_next.error_flag    = ctx[LAST].flt;
      end
      REGION_LSTAR, REGION_RSTAR: begin
        result_next.flux_mass     = f_quo[0].v;
        result_next.flux_momentum = f_quo[1].v;
        result_next.flux_energy   = f_quo[2].v;
        result_next.error_flag    = ctx[LAST].flt || star_err;
      end
      default: begin
        result_next.error_flag    = ctx[LAST].flt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

>>> tb/sv/hllc_interface_flux_core_test.sv
`timescale 1ns / 100ps

module hllc_interface_flux_core_test import hllc_pkg::*; ();

  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN_WAIT  = 220;
  localparam int  N_DIRECTED  = 16;
  localparam int  N_PHASES    = 6;
  localparam int  PHASE_BEATS = 170;
  localparam longint Q1 = 64'sd16777216;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  item_t             item = '0;
  logic              done;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Typed expectation that rides along with the beat on start
  logic    beat_typed = 1'b0;
  result_t beat_exp = '0;

  hllc_interface_flux_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the gamma register and the flux expectations in flight
  logic [GAMMA_W-1:0] gamma_mirror = GAMMA_RESET;
  result_t            flux_expect_q[$];
  int                 fail_count = 0;
  int                 beats_in = 0;
  int                 beats_out = 0;
  int                 region_seen[4] = '{0, 0, 0, 0};
  int                 flagged = 0;
  int                 cycles = 0;
  bit                 sat_seen;

  // ---------------- Q8.24 arithmetic of the flux predictor ----------------
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) begin
      sat_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      sat_seen = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return clamp32(a + b);
  endfunction

  function automatic longint fx_sub(input longint a, input longint b);
    return clamp32(a - b);
  endfunction

  // Round half up, then floor shift
  function automatic longint fx_mul(input longint a, input longint b);
    longint pr;
    pr = a * b + 64'sd8388608;
    return clamp32(pr >>> 24);
  endfunction

  // Round half away from zero; a zero divisor gives zero and flags
  function automatic longint fx_div(input longint a, input longint b);
    longint n;
    longint unsigned un, ud, qt;
    bit neg;
    if (b == 0) begin
      sat_seen = 1'b1;
      return 0;
    end
    n = a * Q1;
    un = (n < 0) ? -n : n;
    ud = (b < 0) ? -b : b;
    neg = (n < 0) != (b < 0);
    qt = (un + ud / 2) / ud;
    return clamp32(neg ? -longint'(qt) : longint'(qt));
  endfunction

  // Root of the magnitude, rounded down
  function automatic longint fx_root(input longint x);
    longint unsigned v, res, bt;
    v = longint'((x < 0) ? -x : x) << 24;
    res = 0;
    bt = 64'd1 << 56;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return clamp32(longint'(res));
  endfunction

  // Velocity, pressure, sound speed and physical flux of one state
  function automatic void state_terms(input longint q[3], input longint g, input longint gm,
                                      output longint u, output longint p, output longint c,
                                      output longint f[3]);
    u = fx_div(q[1], q[0]);
    p = fx_mul(gm, fx_sub(q[2], fx_mul(64'sd8388608, fx_mul(q[1], u))));
    c = fx_root(fx_div(fx_mul(g, p), q[0]));
    f[0] = q[1];
    f[1] = fx_add(fx_mul(q[1], u), p);
    f[2] = fx_mul(u, fx_add(q[2], p));
  endfunction

  function automatic result_t hllc_flux_predict(input item_t it, input logic [GAMMA_W-1:0] gr);
    longint ql[3], qr[3], fl[3], fr[3], qs[3], fs[3], dv[3], res[3];
    longint g, gm, ul, pl, cl, ur, pr, cr, sl, sr, dl, dr, t1, t2, sp, plr;
    longint s, spl, den, num;
    result_t r;
    sat_seen = 1'b0;
    ql = '{longint'(it.rho_left), longint'(it.mom_left), longint'(it.energy_left)};
    qr = '{longint'(it.rho_right), longint'(it.mom_right), longint'(it.energy_right)};
    if (ql[0] <= 0 || qr[0] <= 0) sat_seen = 1'b1;
    g = longint'(gr);
    gm = fx_sub(g, Q1);
    state_terms(ql, g, gm, ul, pl, cl, fl);
    state_terms(qr, g, gm, ur, pr, cr, fr);
    sl = fx_sub((ul < ur) ? ul : ur, (cl > cr) ? cl : cr);
    sr = fx_add((ul > ur) ? ul : ur, (cl > cr) ? cl : cr);
    dl = fx_sub(sl, ul);
    dr = fx_sub(sr, ur);
    t1 = fx_sub(fx_add(fx_sub(pr, pl), fx_mul(ql[1], dl)), fx_mul(qr[1], dr));
    t2 = fx_sub(fx_mul(ql[0], dl), fx_mul(qr[0], dr));
    if (t2 == 0) begin
      sat_seen = 1'b1;
      sp = 0;
    end else begin
      sp = fx_div(t1, t2);
    end
    plr = fx_mul(64'sd8388608,
                 fx_add(fx_add(fx_add(pl, pr), fx_mul(fx_mul(ql[0], dl), fx_sub(sp, ul))),
                        fx_mul(fx_mul(qr[0], dr), fx_sub(sp, ur))));
    dv = '{0, Q1, sp};
    if (sl >= 0) begin
      r.wave_region = REGION_LEFT;
      res = fl;
    end else if (sr <= 0) begin
      r.wave_region = REGION_RIGHT;
      res = fr;
    end else begin
      if (sp >= 0) begin
        r.wave_region = REGION_LSTAR;
        qs = ql;
        fs = fl;
        s = sl;
      end else begin
        r.wave_region = REGION_RSTAR;
        qs = qr;
        fs = fr;
        s = sr;
      end
      spl = fx_mul(s, plr);
      den = fx_sub(s, sp);
      for (int k = 0; k < 3; k++) begin
        num = fx_add(fx_mul(sp, fx_sub(fx_mul(s, qs[k]), fs[k])), fx_mul(spl, dv[k]));
        res[k] = fx_div(num, den);
      end
    end
    r.flux_mass = res[0][31:0];
    r.flux_momentum = res[1][31:0];
    r.flux_energy = res[2][31:0];
    r.error_flag = sat_seen;
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic qv_t to_q(input real x);
    return qv_t'($rtoi(x * 16777216.0));
  endfunction

  // Conservative state from density, velocity and pressure
  function automatic logic [95:0] prim_state(input real rho, input real u, input real p,
                                             input real g);
    return {to_q(rho), to_q(rho * u), to_q(p / (g - 1.0) + 0.5 * rho * u * u)};
  endfunction

  function automatic real rnd(input real lo, input real hi);
    return lo + (hi - lo) * $urandom_range(0, 100000) / 100000.0;
  endfunction

  // Mostly well-formed flow pairs, some raw bit noise
  function automatic item_t random_interface(input real g);
    item_t it;
    real rl, rr, vl, vr, pl, pr;
    if ($urandom_range(0, 9) < 3) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      rl = rnd(0.05, 4.0);
      rr = ($urandom_range(0, 1) != 0) ? rl * rnd(0.5, 1.5) : rnd(0.05, 4.0);
      vl = rnd(-4.0, 4.0);
      vr = ($urandom_range(0, 1) != 0) ? vl + rnd(-0.5, 0.5) : rnd(-4.0, 4.0);
      pl = rnd(0.01, 5.0);
      pr = rnd(0.01, 5.0);
      it = {prim_state(rl, vl, pl, g), prim_state(rr, vr, pr, g)};
    end
    return it;
  endfunction

  // ---------------- drivers ----------------
  // Present one beat, with an optional idle burst in front of it
  task automatic send_beat(input item_t it, input bit typed, input result_t ex,
                           input bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    beat_typed <= typed;
    beat_exp <= ex;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every flux in flight has come back
  task automatic drain_pipe();
    start <= 1'b0;
    while (flux_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write of gamma, then read it back
  task automatic write_gamma(input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_GAMMA, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    gamma_mirror = val[GAMMA_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[GAMMA_W-1:0] !== gamma_mirror) begin
      $display("%0t gamma readback: expected %h actual %h", $time, gamma_mirror, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------- scoreboard ----------------
  always @(posedge clk) begin
    if (!rst) begin
      // Predict at the accepting edge with the gamma then in force
      if (start && !busy) begin
        flux_expect_q.insert(flux_expect_q.size(),
                             beat_typed ? beat_exp : hllc_flux_predict(item, gamma_mirror));
        beats_in++;
      end
      if (done) begin
        if (flux_expect_q.size() == 0) begin
          $display("%0t unexpected flux: actual %p", $time, result);
          fail_count++;
        end else begin
          automatic result_t ex = flux_expect_q.pop_front();
          beats_out++;
          region_seen[result.wave_region]++;
          if (result.error_flag) flagged++;
          if (result.flux_mass !== ex.flux_mass) begin
            $display("%0t flux_mass: expected %h actual %h", $time, ex.flux_mass,
                     result.flux_mass);
            fail_count++;
          end
          if (result.flux_momentum !== ex.flux_momentum) begin
            $display("%0t flux_momentum: expected %h actual %h", $time, ex.flux_momentum,
                     result.flux_momentum);
            fail_count++;
          end
          if (result.flux_energy !== ex.flux_energy) begin
            $display("%0t flux_energy: expected %h actual %h", $time, ex.flux_energy,
                     result.flux_energy);
            fail_count++;
          end
          if (result.wave_region !== ex.wave_region) begin
            $display("%0t wave_region: expected %0d actual %0d", $time, ex.wave_region,
                     result.wave_region);
            fail_count++;
          end
          if (result.error_flag !== ex.error_flag) begin
            $display("%0t error_flag: expected %b actual %b", $time, ex.error_flag,
                     result.error_flag);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------- directed table ----------------
  typedef struct {
    item_t   it;
    bit      typed;
    result_t ex;
  } dir_row_t;

  dir_row_t dir_rows[N_DIRECTED];

  initial begin
    logic [31:0] phase_gamma[N_PHASES];
    real g_gen;

    foreach (dir_rows[i]) begin
      dir_rows[i].typed = 1'b0;
      dir_rows[i].ex = '0;
    end
    // Vacuum: zero divisors everywhere, zero flux, flagged
    dir_rows[0].it = '0;
    dir_rows[0].typed = 1'b1;
    dir_rows[0].ex = '{flux_mass: '0, flux_momentum: '0, flux_energy: '0,
                       wave_region: REGION_LEFT, error_flag: 1'b1};
    dir_rows[1].it = {prim_state(1.0, 0.0, 1.0, 1.4), prim_state(0.125, 0.0, 0.1, 1.4)};
    dir_rows[2].it = {prim_state(1.0, 3.0, 1.0, 1.4), prim_state(1.0, 3.0, 1.0, 1.4)};
    dir_rows[3].it = {prim_state(1.0, -3.0, 1.0, 1.4), prim_state(1.0, -3.0, 1.0, 1.4)};
    dir_rows[4].it = {prim_state(1.0, 0.5, 1.0, 1.4), prim_state(1.0, 0.5, 1.0, 1.4)};
    dir_rows[5].it = {prim_state(1.0, -0.5, 1.0, 1.4), prim_state(1.0, -0.5, 1.0, 1.4)};
    dir_rows[6].it = {6{32'h7fff_ffff}};
    dir_rows[7].it = {6{32'h8000_0000}};
    // Negative density on the left
    dir_rows[8].it = {to_q(-1.0), to_q(0.5), to_q(2.0), prim_state(1.0, 0.0, 1.0, 1.4)};
    // Negative pressure: magnitude under the root
    dir_rows[9].it = {to_q(1.0), to_q(2.0), to_q(-1.0), to_q(1.0), to_q(-2.0), to_q(-1.0)};
    // Zero density on the right only
    dir_rows[10].it = {prim_state(1.0, 0.2, 1.0, 1.4), 32'd0, to_q(1.0), to_q(1.0)};
    dir_rows[11].it = {6{32'haaaa_aaaa}};
    dir_rows[12].it = {6{32'h5555_5555}};
    // Momentum far beyond the range of the products
    dir_rows[13].it = {to_q(1.0), 32'h7fff_ffff, to_q(2.0), to_q(1.0), 32'h8000_0000,
                       to_q(2.0)};
    dir_rows[14].it = {prim_state(1.0, 0.0, 50.0, 1.4), prim_state(1.0, 0.0, 0.01, 1.4)};
    // Smallest positive density
    dir_rows[15].it = {32'd1, 32'd1, 32'd1, 32'd1, -32'sd1, 32'd1};

    phase_gamma = '{32'd16777216, 32'd50331648, 32'd27962027, 32'hffff_ffff, 32'd0,
                    32'd23488102};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset gamma
    foreach (dir_rows[i])
      send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].ex, 1'b1);
    drain_pipe();

    // Random phases, one gamma setting each, the extremes among them
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_gamma(phase_gamma[ph]);
      g_gen = (gamma_mirror > 26'd18000000 && gamma_mirror <= 26'd50331648)
              ? gamma_mirror / 16777216.0 : 1.4;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Drop idling entirely in the last phase; ph 2 midway waits for a full drain
        send_beat(random_interface(g_gen), 1'b0, '0, ph < N_PHASES - 1 && (n / 40) % 2 == 0);
        if (ph == 2 && n == PHASE_BEATS / 2) drain_pipe();
      end
      drain_pipe();
    end

    // Wait out the pipe for stray results
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d interfaces over %0d gamma settings; %0d fluxes checked, %0d flagged.",
             beats_in, N_PHASES + 1, beats_out, flagged);
    $display("Regions seen: left %0d, right %0d, left star %0d, right star %0d.",
             region_seen[0], region_seen[1], region_seen[2], region_seen[3]);
    if (fail_count == 0 && flux_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/hllc_pkg.sv
rtl/hllc_div.sv
rtl/hllc_sqrt.sv
rtl/hllc_interface_flux_core.sv
tb/sv/hllc_interface_flux_core_test.sv
